### rtl/four_level_priority_job_queue_assert.svh
// Assertion macros for the four-level priority job queue.
// Included by the RTL files that carry concurrent checks; clocked on clk_i, reset by rst_ni.
`ifndef FOUR_LEVEL_PRIORITY_JOB_QUEUE_ASSERT_SVH
`define FOUR_LEVEL_PRIORITY_JOB_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Check after reset has been released.
`define FPJQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fpjq: check failed")
// Check at every edge, reset included.
`define FPJQ_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("fpjq: invariant failed")
`else
`define FPJQ_ASSERT(name, prop)
`define FPJQ_ASSERT_ALWAYS(name, prop)
`endif

`endif

### rtl/fpjq_pkg.sv
// Shared types and codes of the four-level priority job queue.
// No dependencies; used by the channel interfaces and the top level.
package fpjq_pkg;

  localparam int unsigned NumLevels = 4;
  localparam int unsigned LevelW    = 2;
  localparam int unsigned HandleW   = 16;

  typedef logic [LevelW-1:0]  level_t;
  typedef logic [HandleW-1:0] handle_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

### rtl/fpjq_if.sv
// Valid/ready channel interfaces of the four-level priority job queue.
// Depends on fpjq_pkg for the payload types.
interface fpjq_in_if import fpjq_pkg::*;;
  logic    valid;
  logic    ready;
  op_e     op;
  level_t  level;
  handle_t job_handle;

  modport source (output valid, output op, output level, output job_handle, input ready);
  modport sink   (input valid, input op, input level, input job_handle, output ready);
endinterface

interface fpjq_out_if import fpjq_pkg::*;;
  logic    valid;
  logic    ready;
  status_e status;
  handle_t fetched_handle;
  level_t  served_level;

  modport source (output valid, output status, output fetched_handle, output served_level,
                  input ready);
  modport sink   (input valid, input status, input fetched_handle, input served_level,
                  output ready);
endinterface

### rtl/four_level_priority_job_queue.sv
// Four strict-priority FIFO queues of job handles with one shared handle memory.
// Depends on fpjq_pkg, fpjq_if.sv and four_level_priority_job_queue_assert.svh.
//
// Usage:
//   in_i  carries one item per handshake: op (push or fetch), level, job_handle.
//         A push appends job_handle to the queue of its level, or is dropped with
//         status FULL when that queue holds QUEUE_DEPTH handles. A fetch pops the
//         head of the highest non-empty queue at or below its level; status EMPTY
//         when none qualifies. The low queue is always eligible.
//   out_o carries exactly one result per item, in order: status, fetched_handle
//         (zero unless a fetch succeeds) and served_level.
//   Throughput: one item per cycle while out_o does not stall. Each item makes
//   at most one access (one write or one read) to the handle memory, and queue
//   selection is a 4-way priority pick on the occupancy counters.
//   An accepted item passes through the memory read register and then the output
//   register, which form a two-stage pipeline.
//   When out_o stalls, the output register holds and one more item is still
//   taken into the read stage; in_i.ready then drops until out_o moves.
//   Reset empties every queue at once (pointers and counters clear); no clearing
//   pass over the memory is needed.
`include "four_level_priority_job_queue_assert.svh"

module four_level_priority_job_queue import fpjq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpjq_in_if.sink     in_i,
  fpjq_out_if.source  out_o
);

  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned StoreW = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;
  localparam int unsigned MemD   = NumLevels << PtrW;

  typedef logic [PtrW-1:0]   ptr_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [StoreW-1:0] store_t;

  function automatic ptr_t next_ptr(input ptr_t p);
    next_ptr = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Queue bookkeeping
  ptr_t head_q [NumLevels];
  ptr_t head_d [NumLevels];
  ptr_t tail_q [NumLevels];
  ptr_t tail_d [NumLevels];
  cnt_t cnt_q  [NumLevels];
  cnt_t cnt_d  [NumLevels];

  store_t mem [MemD];

  // Read stage
  logic    a_valid_q, a_valid_d;
  status_e a_status_q;
  level_t  a_level_q;
  logic    a_pop_q;
  store_t  rdata_q;

  // Output stage
  logic    b_valid_q, b_valid_d;
  status_e b_status_q;
  level_t  b_level_q;
  handle_t b_handle_q;

  logic    acc;
  logic    b_take;
  logic    found;
  level_t  chosen;
  level_t  sel_lvl;
  logic    push_ok;
  logic    pop_ok;
  status_e status_c;

  assign b_take     = a_valid_q && (!b_valid_q || out_o.ready);
  assign in_i.ready = !a_valid_q || b_take;
  assign acc        = in_i.valid && in_i.ready;

  // Highest non-empty queue at or below the fetch ceiling
  always_comb begin
    found  = 1'b0;
    chosen = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if ((cnt_q[i] != '0) && (level_t'(i) <= in_i.level)) begin
        found  = 1'b1;
        chosen = level_t'(i);
      end
    end
  end

  assign sel_lvl = (in_i.op == OP_PUSH) ? in_i.level : chosen;
  assign push_ok = (in_i.op == OP_PUSH) && (cnt_q[sel_lvl] != CntW'(QUEUE_DEPTH));
  assign pop_ok  = (in_i.op == OP_FETCH) && found;

  always_comb begin
    case (in_i.op)
      OP_PUSH:  status_c = push_ok ? ST_OK : ST_FULL;
      OP_FETCH: status_c = found ? ST_OK : ST_EMPTY;
      default:  status_c = ST_OK;
    endcase
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (acc && push_ok) begin
      tail_d[sel_lvl] = next_ptr(tail_q[sel_lvl]);
      cnt_d[sel_lvl]  = cnt_q[sel_lvl] + 1'b1;
    end
    if (acc && pop_ok) begin
      head_d[sel_lvl] = next_ptr(head_q[sel_lvl]);
      cnt_d[sel_lvl]  = cnt_q[sel_lvl] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Handle memory: at most one write or one registered read per item
  always_ff @(posedge clk_i) begin
    if (acc && push_ok) begin
      mem[{sel_lvl, tail_q[sel_lvl]}] <= in_i.job_handle[StoreW-1:0];
    end
    if (acc && pop_ok) begin
      rdata_q <= mem[{sel_lvl, head_q[sel_lvl]}];
    end
  end

  assign a_valid_d = acc ? 1'b1 : (b_take ? 1'b0 : a_valid_q);
  assign b_valid_d = b_take ? 1'b1 : (out_o.ready ? 1'b0 : b_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_status_q <= status_c;
      a_level_q  <= sel_lvl;
      a_pop_q    <= pop_ok;
    end
    if (b_take) begin
      b_status_q <= a_status_q;
      b_level_q  <= a_level_q;
      b_handle_q <= a_pop_q ? HandleW'(rdata_q) : '0;
    end
  end

  assign out_o.valid          = b_valid_q;
  assign out_o.status         = b_status_q;
  assign out_o.fetched_handle = b_handle_q;
  assign out_o.served_level   = b_level_q;

  for (genvar g = 0; g < NumLevels; g++) begin : g_chk
    `FPJQ_ASSERT(a_cnt_bound, cnt_q[g] <= CntW'(QUEUE_DEPTH));
    // Pointers meet only when the queue is empty or full
    `FPJQ_ASSERT(a_ptr_meet,
                 (head_q[g] == tail_q[g]) ==
                 ((cnt_q[g] == '0) || (cnt_q[g] == CntW'(QUEUE_DEPTH))));
    `FPJQ_ASSERT(a_push_cnt,
                 (acc && push_ok && (sel_lvl == level_t'(g))) |=>
                 (cnt_q[g] == $past(cnt_q[g]) + 1'b1));
  end

endmodule

### verif/four_level_priority_job_queue_tb.sv
// Self-checking bench for four_level_priority_job_queue: push/fetch items in, one reply out.
// Depends on fpjq_pkg, fpjq_if.sv and the top level; keeps its own model of the four queues.
`timescale 1ns / 1ps

module four_level_priority_job_queue_tb import fpjq_pkg::*;;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned HandleBits = 16;
  localparam int unsigned PhaseItems = 360;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    op_e     op;
    level_t  level;
    handle_t handle;
  } job_req_t;

  typedef struct packed {
    status_e status;
    handle_t handle;
    level_t  level;
  } job_reply_t;

  logic clk_i;
  logic rst_ni;

  fpjq_in_if  jobs_in ();
  fpjq_out_if jobs_out ();

  four_level_priority_job_queue #(
    .QUEUE_DEPTH(QueueDepth),
    .HANDLE_BITS(HandleBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (jobs_in),
    .out_o (jobs_out)
  );

  job_req_t    job_backlog[$];
  job_reply_t  expected_replies[$];
  handle_t     level_fifo[NumLevels][$];
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  logic        hold_req;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned cycle_count;

  // Strict-priority pick: the low queue is always eligible, ceiling bounds the rest.
  function automatic job_reply_t schedule_job(job_req_t req);
    job_reply_t rsp;
    int         lv;
    rsp.status = ST_OK;
    rsp.handle = '0;
    rsp.level  = req.level;
    if (req.op == OP_PUSH) begin
      if (level_fifo[req.level].size() >= QueueDepth) begin
        rsp.status = ST_FULL;
      end else begin
        level_fifo[req.level].push_back(req.handle);
      end
    end else begin
      rsp.status = ST_EMPTY;
      rsp.level  = '0;
      for (lv = int'(req.level); lv >= 0 && rsp.status == ST_EMPTY; lv--) begin
        if (level_fifo[lv].size() != 0) begin
          rsp.status = ST_OK;
          rsp.handle = level_fifo[lv][0];
          level_fifo[lv].delete(0);
          rsp.level  = level_t'(lv);
        end
      end
    end
    return rsp;
  endfunction

  function automatic job_req_t make_job(op_e op, int unsigned lvl, int unsigned h);
    job_req_t req;
    req.op     = op;
    req.level  = level_t'(lvl);
    req.handle = handle_t'(h);
    return req;
  endfunction

  // Bursts: push-heavy on one focus level can fill it, fetch-heavy drains, balanced mixes.
  task automatic add_random_jobs(int unsigned count);
    int unsigned added;
    int unsigned burst;
    int unsigned push_pct;
    int unsigned focus;
    int unsigned k;
    op_e         op;
    int unsigned lvl;
    added = 0;
    while (added < count) begin
      burst = $urandom_range(40, 8);
      focus = $urandom_range(3);
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      for (k = 0; k < burst && added < count; k++) begin
        op  = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_FETCH;
        lvl = (op == OP_PUSH && $urandom_range(99) < 70) ? focus : $urandom_range(3);
        job_backlog.push_back(make_job(op, lvl, $urandom));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (job_backlog.size() != 0 || jobs_in.valid || expected_replies.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: record the accepted item, then offer the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jobs_in.valid      <= 1'b0;
      jobs_in.op         <= OP_PUSH;
      jobs_in.level      <= '0;
      jobs_in.job_handle <= '0;
    end else begin
      if (jobs_in.valid && jobs_in.ready) begin
        expected_replies.push_back(schedule_job(make_job(jobs_in.op, jobs_in.level,
                                                         jobs_in.job_handle)));
      end
      if (!jobs_in.valid || jobs_in.ready) begin
        if (job_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          jobs_in.valid      <= 1'b1;
          jobs_in.op         <= job_backlog[0].op;
          jobs_in.level      <= job_backlog[0].level;
          jobs_in.job_handle <= job_backlog[0].handle;
          job_backlog.delete(0);
        end else begin
          jobs_in.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the reply side, counted down on its own.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jobs_out.ready <= 1'b0;
    end else if (hold_req || hold_left != 0) begin
      jobs_out.ready <= 1'b0;
    end else begin
      jobs_out.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_reply
    job_reply_t want;
    if (rst_ni && jobs_out.valid && jobs_out.ready) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected reply: status %0d handle %h level %0d",
                   jobs_out.status, jobs_out.fetched_handle, jobs_out.served_level);
        end
      end else begin
        want = expected_replies[0];
        expected_replies.delete(0);
        if (jobs_out.status !== want.status || jobs_out.fetched_handle !== want.handle ||
            jobs_out.served_level !== want.level) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("reply mismatch: exp status %0d handle %h level %0d, got %0d %h %0d",
                     want.status, want.handle, want.level, jobs_out.status,
                     jobs_out.fetched_handle, jobs_out.served_level);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("four_level_priority_job_queue_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    mismatches     = 0;
    cycle_count    = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty fetches at every ceiling, extreme handles, priority order, ineligible levels.
    for (int unsigned c = 0; c < NumLevels; c++) begin
      job_backlog.push_back(make_job(OP_FETCH, c, 16'hFFFF));
    end
    job_backlog.push_back(make_job(OP_PUSH, 0, 16'h0000));
    job_backlog.push_back(make_job(OP_PUSH, 1, 16'hFFFF));
    job_backlog.push_back(make_job(OP_PUSH, 2, 16'hA5A5));
    job_backlog.push_back(make_job(OP_PUSH, 3, 16'h5A5A));
    job_backlog.push_back(make_job(OP_PUSH, 0, 16'hFFFF));
    job_backlog.push_back(make_job(OP_FETCH, 1, 16'h0000));
    job_backlog.push_back(make_job(OP_FETCH, 0, 16'h1234));
    job_backlog.push_back(make_job(OP_FETCH, 3, 16'h0000));
    job_backlog.push_back(make_job(OP_FETCH, 2, 16'h0000));
    job_backlog.push_back(make_job(OP_FETCH, 3, 16'h0000));
    job_backlog.push_back(make_job(OP_FETCH, 3, 16'h0000));
    job_backlog.push_back(make_job(OP_PUSH, 3, 16'h8001));
    job_backlog.push_back(make_job(OP_FETCH, 2, 16'h0000));
    job_backlog.push_back(make_job(OP_FETCH, 3, 16'h0000));
    wait_drained();

    add_random_jobs(PhaseItems);
    wait_drained();

    send_idle_pct = 87;
    add_random_jobs(PhaseItems);
    wait_drained();

    send_idle_pct  = 0;
    sink_stall_pct = 87;
    add_random_jobs(PhaseItems);
    wait_drained();

    send_idle_pct  = 29;
    sink_stall_pct = 29;
    add_random_jobs(PhaseItems);
    wait_drained();

    // Hold the reply side while items keep coming, so the input stalls.
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    add_random_jobs(60);
    hold_req = 1'b1;
    while (hold_left == 0) @(negedge clk_i);
    hold_req = 1'b0;
    while (hold_left != 0) @(negedge clk_i);
    wait_drained();

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("four_level_priority_job_queue_tb: done, clean");
    end else begin
      $display("four_level_priority_job_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

### four_level_priority_job_queue.f
+incdir+rtl
rtl/fpjq_pkg.sv
rtl/fpjq_if.sv
rtl/four_level_priority_job_queue.sv
verif/four_level_priority_job_queue_tb.sv
